// ===== rtl/core/cfes_pkg.sv =====
// Shared types and constants of the channel fade envelope sequencer.
package cfes_pkg;

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_DELAY = 3'd1;
  localparam logic [2:0] ST_UP    = 3'd2;
  localparam logic [2:0] ST_HOLD  = 3'd3;
  localparam logic [2:0] ST_DOWN  = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_IDLE  = 3'd6;

  localparam logic [3:0] SEL_DELAY   = 4'd0;
  localparam logic [3:0] SEL_RISE    = 4'd1;
  localparam logic [3:0] SEL_HOLD    = 4'd2;
  localparam logic [3:0] SEL_FALL    = 4'd3;
  localparam logic [3:0] SEL_REPEAT  = 4'd4;
  localparam logic [3:0] SEL_LEVEL   = 4'd5;
  localparam logic [3:0] SEL_REPMODE = 4'd6;
  localparam logic [3:0] SEL_OUTMODE = 4'd7;
  localparam logic [3:0] SEL_ENABLE  = 4'd8;
  localparam logic [3:0] SEL_TOP     = 4'd9;
  localparam logic [3:0] SEL_BOTTOM  = 4'd10;

  localparam logic [3:0] RM_FOREVER = 4'd0;
  localparam logic [3:0] RM_OFF     = 4'd1;
  localparam logic [3:0] RM_ON      = 4'd2;

  localparam logic [3:0] OM_NORMAL   = 4'd0;
  localparam logic [3:0] OM_INVERT   = 4'd1;
  localparam logic [3:0] OM_THRESH   = 4'd2;
  localparam logic [3:0] OM_FOLD     = 4'd3;
  localparam logic [3:0] OM_FOLD_INV = 4'd4;

  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_FIRST_SLOT = 2'd1;
  localparam logic [1:0] REG_CHAN_COUNT = 2'd2;

  localparam int MAX_CHANNELS = 32;

  typedef struct packed {
    logic [2:0]  stage;
    logic [15:0] step;
    logic [7:0]  cur;
    logic [15:0] reps;
    logic [15:0] delay;
    logic [15:0] rise;
    logic [15:0] hold;
    logic [15:0] fall;
    logic [15:0] target;
    logic [7:0]  upper;
    logic [7:0]  lower;
    logic [7:0]  mode;
    logic [7:0]  last_lvl;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{
    stage:    ST_IDLE,
    step:     16'd0,
    cur:      8'd0,
    reps:     16'd0,
    delay:    16'd100,
    rise:     16'd10,
    hold:     16'd100,
    fall:     16'd10,
    target:   16'd0,
    upper:    8'd255,
    lower:    8'd0,
    mode:     8'd0,
    last_lvl: 8'd0
  };

  typedef struct packed {
    logic        is_write;
    logic [3:0]  sel;
    logic [15:0] value;
  } upd_ctl_t;

endpackage

// ===== rtl/core/cfes_if.sv =====
// Channel interfaces of the channel fade envelope sequencer.
interface cfes_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  range_first;
  logic [4:0]  range_last;
  logic [3:0]  field_select;
  logic [15:0] value;

  modport source (output valid, cmd, range_first, range_last, field_select, value,
                  input ready);
  modport sink (input valid, cmd, range_first, range_last, field_select, value,
                output ready);
endinterface

interface cfes_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] slot;
  logic [7:0] level;
  logic [2:0] stage_code;
  logic       last;

  modport source (output valid, slot, level, stage_code, last, input ready);
  modport sink (input valid, slot, level, stage_code, last, output ready);
endinterface

interface cfes_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cfes_chan_mem.sv =====
// Channel record memory with per-entry valid bits standing in for the reset values.
module cfes_chan_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output cfes_pkg::chan_rec_t rd_rec,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  cfes_pkg::chan_rec_t wr_rec
);

  cfes_pkg::chan_rec_t mem [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  cfes_pkg::chan_rec_t rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_rec = rd_vld_r ? rd_data_r : cfes_pkg::REC_RESET;

endmodule

// ===== rtl/core/cfes_update.sv =====
// Record update: field writes, envelope stepping and output level mapping.
module cfes_update #(
  parameter int FULL_SCALE = 255
) (
  input  cfes_pkg::upd_ctl_t  ctl,
  input  cfes_pkg::chan_rec_t rec_in,
  output cfes_pkg::chan_rec_t rec_out,
  output logic [7:0]          level,
  output logic [2:0]          stage_code
);

  localparam logic signed [10:0] FS_S   = 11'(FULL_SCALE);
  localparam logic signed [10:0] HALF_S = 11'(FULL_SCALE / 2);

  cfes_pkg::chan_rec_t r;
  logic signed [10:0]  g;
  logic signed [10:0]  fold;
  logic signed [10:0]  mapped;
  logic [7:0]          lvl;

  always_comb begin
    r      = rec_in;
    g      = '0;
    fold   = '0;
    mapped = '0;
    lvl    = rec_in.last_lvl;
    if (ctl.is_write) begin
      case (ctl.sel)
        cfes_pkg::SEL_DELAY:   r.delay  = ctl.value;
        cfes_pkg::SEL_RISE:    r.rise   = ctl.value;
        cfes_pkg::SEL_HOLD:    r.hold   = ctl.value;
        cfes_pkg::SEL_FALL:    r.fall   = ctl.value;
        cfes_pkg::SEL_REPEAT:  r.target = ctl.value;
        cfes_pkg::SEL_LEVEL:   r.cur    = ctl.value[7:0];
        cfes_pkg::SEL_REPMODE: r.mode   = {r.mode[7:4], ctl.value[3:0]};
        cfes_pkg::SEL_OUTMODE: begin
          if (ctl.value[3:0] <= cfes_pkg::OM_FOLD_INV) begin
            r.mode = {ctl.value[3:0], r.mode[3:0]};
          end
        end
        cfes_pkg::SEL_ENABLE: begin
          r.stage = (ctl.value != 16'd0) ? cfes_pkg::ST_START : cfes_pkg::ST_IDLE;
          r.reps  = 16'd0;
        end
        cfes_pkg::SEL_TOP:    r.upper = ctl.value[7:0];
        cfes_pkg::SEL_BOTTOM: r.lower = ctl.value[7:0];
        default: ;
      endcase
    end else begin
      case (r.stage)
        cfes_pkg::ST_START: begin
          r.step  = r.delay;
          r.stage = cfes_pkg::ST_DELAY;
        end
        cfes_pkg::ST_DELAY: begin
          if (r.step == 16'd0) begin
            r.step  = r.rise;
            r.stage = cfes_pkg::ST_UP;
          end else begin
            r.step = r.step - 16'd1;
          end
        end
        cfes_pkg::ST_UP: begin
          if (r.step == 16'd0) begin
            if (r.cur >= r.upper) begin
              r.step  = r.hold;
              r.stage = cfes_pkg::ST_HOLD;
            end else begin
              r.cur  = r.cur + 8'd1;
              r.step = r.rise;
            end
          end else begin
            r.step = r.step - 16'd1;
          end
        end
        cfes_pkg::ST_HOLD: begin
          if (r.step == 16'd0) begin
            r.step  = r.fall;
            r.stage = cfes_pkg::ST_DOWN;
          end else begin
            r.step = r.step - 16'd1;
          end
        end
        cfes_pkg::ST_DOWN: begin
          if (r.step == 16'd0) begin
            if (r.cur <= r.lower) begin
              r.stage = cfes_pkg::ST_END;
            end else begin
              r.cur = r.cur - 8'd1;
            end
            r.step = r.fall;
          end else begin
            r.step = r.step - 16'd1;
          end
        end
        cfes_pkg::ST_END: begin
          case (r.mode[3:0])
            cfes_pkg::RM_FOREVER: r.stage = cfes_pkg::ST_START;
            cfes_pkg::RM_OFF, cfes_pkg::RM_ON: begin
              if (r.reps >= r.target) begin
                if (r.step == 16'd0) begin
                  if (r.mode[3:0] == cfes_pkg::RM_OFF && r.cur > r.lower) begin
                    r.cur = r.cur - 8'd1;
                  end else if (r.mode[3:0] == cfes_pkg::RM_ON && r.cur < r.upper) begin
                    r.cur = r.cur + 8'd1;
                  end else begin
                    r.stage = cfes_pkg::ST_IDLE;
                    r.reps  = 16'd0;
                  end
                  r.step = r.fall;
                end else begin
                  r.step = r.step - 16'd1;
                end
              end else begin
                r.stage = cfes_pkg::ST_START;
                r.reps  = r.reps + 16'd1;
              end
            end
            default: begin
              r.stage = cfes_pkg::ST_IDLE;
              r.reps  = 16'd0;
            end
          endcase
        end
        default: ;
      endcase

      g = signed'({3'b000, r.cur});
      if (g <= HALF_S - 11'sd1) begin
        fold = (HALF_S - 11'sd1 - g) * 11'sd2 + 11'sd1;
      end else begin
        fold = (g - HALF_S) * 11'sd2 + 11'sd1;
      end
      case (r.mode[7:4])
        cfes_pkg::OM_NORMAL:   mapped = g;
        cfes_pkg::OM_INVERT:   mapped = FS_S - g;
        cfes_pkg::OM_THRESH:   mapped = (g >= HALF_S) ? signed'({3'b000, r.upper})
                                                      : signed'({3'b000, r.lower});
        cfes_pkg::OM_FOLD:     mapped = fold;
        cfes_pkg::OM_FOLD_INV: mapped = FS_S - fold;
        default:               mapped = signed'({3'b000, r.last_lvl});
      endcase
      if (mapped < 11'sd0) begin
        lvl = 8'd0;
      end else if (mapped > 11'sd255) begin
        lvl = 8'd255;
      end else begin
        lvl = mapped[7:0];
      end
      r.last_lvl = lvl;
    end
  end

  assign rec_out    = r;
  assign level      = lvl;
  assign stage_code = r.stage;

endmodule

// ===== rtl/core/channel_fade_envelope_sequencer_unit.sv =====
// Top level of the channel fade envelope sequencer: command control, registers and results.
//
// Each channel's settings and envelope state live in one record of a single-port-read,
// single-port-write memory; an item walks the records it touches one per cycle, reading
// one record ahead while the previous one is updated and written back. A tick over N
// active channels gives N results, the last one flagged; a field write over a range
// of M channels gives no result. A tick with the engine disabled, a zero channel count
// or an empty or out-of-range write range completes at acceptance. A stalled result
// stalls the walk. After reset every record reads as its default values at once, with
// no clearing pass.
module channel_fade_envelope_sequencer_unit #(
  parameter int CHANNELS   = 32,
  parameter int FULL_SCALE = 255
) (
  input logic           clk,
  input logic           rst_n,
  cfes_in_if.sink       in_ch,
  cfes_out_if.source    out_ch,
  cfes_cfg_if.sink      cfg_ch
);

  localparam int EFF     = (CHANNELS < cfes_pkg::MAX_CHANNELS) ? CHANNELS
                                                               : cfes_pkg::MAX_CHANNELS;
  localparam int AW      = (EFF > 1) ? $clog2(EFF) : 1;
  localparam int LAST_CH = EFF - 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } fsm_t;

  fsm_t               state_r, state_nxt;
  logic               engine_en_r;
  logic [8:0]         first_slot_r;
  logic [5:0]         chan_count_r;
  cfes_pkg::upd_ctl_t ctl_r;
  logic [5:0]         a_idx_r, a_end_r;
  logic               b_vld_r, b_last_r;
  logic [5:0]         b_idx_r;
  logic               out_vld_r, out_last_r;
  logic [9:0]         out_slot_r;
  logic [7:0]         out_level_r;
  logic [2:0]         out_stage_r;

  logic               in_acc;
  logic [4:0]         hi_cl;
  logic [5:0]         n_cl;
  logic               nonempty;
  logic [5:0]         start_idx, end_idx;
  logic               advance;
  logic               rd_en, wr_en;
  cfes_pkg::chan_rec_t rd_rec, wr_rec;
  logic [7:0]         upd_level;
  logic [2:0]         upd_stage;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    hi_cl = (in_ch.range_last > 5'(LAST_CH)) ? 5'(LAST_CH) : in_ch.range_last;
    n_cl  = (chan_count_r > 6'(EFF)) ? 6'(EFF) : chan_count_r;
    if (in_ch.cmd) begin
      nonempty  = (in_ch.range_first <= hi_cl);
      start_idx = {1'b0, in_ch.range_first};
      end_idx   = {1'b0, hi_cl};
    end else begin
      nonempty  = engine_en_r && (n_cl != 6'd0);
      start_idx = 6'd0;
      end_idx   = n_cl - 6'd1;
    end
  end

  assign advance = !b_vld_r || ctl_r.is_write || !out_vld_r || out_ch.ready;
  assign rd_en   = (state_r == S_RUN) && advance;
  assign wr_en   = b_vld_r && advance;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && nonempty) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (advance && a_idx_r == a_end_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (advance) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      engine_en_r  <= 1'b0;
      first_slot_r <= 9'd0;
      chan_count_r <= 6'd1;
      b_vld_r      <= 1'b0;
      out_vld_r    <= 1'b0;
      ctl_r        <= '0;
      a_idx_r      <= '0;
      a_end_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cfes_pkg::REG_ENABLE:     engine_en_r  <= cfg_ch.data[0];
          cfes_pkg::REG_FIRST_SLOT: first_slot_r <= cfg_ch.data;
          cfes_pkg::REG_CHAN_COUNT: chan_count_r <= cfg_ch.data[5:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        ctl_r   <= '{is_write: in_ch.cmd, sel: in_ch.field_select, value: in_ch.value};
        a_idx_r <= start_idx;
        a_end_r <= end_idx;
      end else if (rd_en) begin
        a_idx_r <= a_idx_r + 6'd1;
      end
      if (advance) begin
        b_vld_r <= rd_en;
      end
      if (wr_en && !ctl_r.is_write) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_idx_r  <= a_idx_r;
      b_last_r <= (a_idx_r == a_end_r);
    end
    if (wr_en && !ctl_r.is_write) begin
      out_slot_r  <= {1'b0, first_slot_r} + {4'd0, b_idx_r};
      out_level_r <= upd_level;
      out_stage_r <= upd_stage;
      out_last_r  <= b_last_r;
    end
  end

  cfes_chan_mem #(
    .DEPTH (EFF),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (AW'(a_idx_r)),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (AW'(b_idx_r)),
    .wr_rec  (wr_rec)
  );

  cfes_update #(
    .FULL_SCALE (FULL_SCALE)
  ) u_update (
    .ctl        (ctl_r),
    .rec_in     (rd_rec),
    .rec_out    (wr_rec),
    .level      (upd_level),
    .stage_code (upd_stage)
  );

  assign out_ch.valid      = out_vld_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.level      = out_level_r;
  assign out_ch.stage_code = out_stage_r;
  assign out_ch.last       = out_last_r;

endmodule
